// ----- hdl/hhfl_pkg.sv -----
// Shared types, constants and helper functions for the HTTP header field locator.
// No dependencies; every other file of the block refers to it by scoped names.
package hhfl_pkg;

    localparam int PAT_MAX_BYTES = 8;
    localparam int PKT_MAX_BYTES = 2048;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 12;
    localparam int PLEN_W        = 4;
    localparam int WIN_IDX_W     = 3;
    localparam int PAT_W         = PAT_MAX_BYTES * BYTE_W;
    localparam int CFG_DATA_W    = PAT_W;
    localparam int CFG_IDX_W     = 2;
    localparam int HES_W         = 3;

    localparam logic [HES_W-1:0]  HES_END      = 3'd4;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [BYTE_W-1:0] TERM_RESET   = 8'h0D;
    localparam logic [PLEN_W-1:0] PLEN_RESET   = 4'd1;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_MATCH   = 2'd1,
        VERDICT_PARTIAL = 2'd2
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN = 2'd0,
        CFG_LENGTH  = 2'd1,
        CFG_TERM    = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_VALUE  = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] start_byte;
    } win_view_t;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic logic [PLEN_W-1:0] eff_plen(input logic [PLEN_W-1:0] p);
        if (p == '0)
        begin
            return PLEN_W'(1);
        end
        if (p > PLEN_W'(PAT_MAX_BYTES))
        begin
            return PLEN_W'(PAT_MAX_BYTES);
        end
        return p;
    endfunction

endpackage

// ----- hdl/hhfl_byte_if.sv -----
// Input channel: one payload byte per beat with its end-of-packet mark.
// Depends on hhfl_pkg for widths.
interface hhfl_byte_if;
    logic                        valid;
    logic                        ready;
    logic [hhfl_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- hdl/hhfl_result_if.sv -----
// Output channel: one verdict beat per packet.
// Depends on hhfl_pkg for widths.
interface hhfl_result_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 verdict;
    logic [hhfl_pkg::CNT_W-1:0] value_offset;
    logic [hhfl_pkg::CNT_W-1:0] value_length;

    modport source (output valid, output verdict, output value_offset, output value_length,
                    input ready);
    modport sink   (input valid, input verdict, input value_offset, input value_length,
                    output ready);
endinterface

// ----- hdl/hhfl_window.sv -----
// Sliding window of the newest payload bytes and the exact pattern compare on it.
// Depends on hhfl_pkg for widths and the window view struct.
module hhfl_window
(
    input  logic                             clk,
    input  logic                             shift,
    input  logic [hhfl_pkg::BYTE_W-1:0]      data_byte,
    input  logic [hhfl_pkg::PLEN_W-1:0]      plen,
    input  logic [hhfl_pkg::PAT_W-1:0]       pattern,
    output hhfl_pkg::win_view_t              view
);

    logic [hhfl_pkg::BYTE_W-1:0] win_reg  [hhfl_pkg::PAT_MAX_BYTES];
    logic [hhfl_pkg::BYTE_W-1:0] win_next [hhfl_pkg::PAT_MAX_BYTES];

    always_comb
    begin
        win_next[0] = data_byte;
        for (int k = 1; k < hhfl_pkg::PAT_MAX_BYTES; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        logic [hhfl_pkg::PLEN_W-1:0]    plen_m1;
        logic [hhfl_pkg::PLEN_W-1:0]    pos;
        logic [hhfl_pkg::BYTE_W-1:0]    pat_b;
        plen_m1        = plen - hhfl_pkg::PLEN_W'(1);
        view.hit        = 1'b1;
        view.start_byte = win_next[plen_m1[hhfl_pkg::WIN_IDX_W-1:0]];
        for (int k = 0; k < hhfl_pkg::PAT_MAX_BYTES; k++)
        begin
            pos   = plen_m1 - hhfl_pkg::PLEN_W'(k);
            pat_b = pattern[k*hhfl_pkg::BYTE_W +: hhfl_pkg::BYTE_W];
            if (hhfl_pkg::PLEN_W'(k) < plen &&
                win_next[pos[hhfl_pkg::WIN_IDX_W-1:0]] != pat_b)
            begin
                view.hit = 1'b0;
            end
        end
    end

endmodule

// ----- hdl/http_header_field_locator_unit.sv -----
// Top level of the HTTP header field locator: input stage, packet state and verdict register.
// Depends on hhfl_pkg, hhfl_byte_if, hhfl_result_if and hhfl_window.
//
// Usage:
//   bytes  : payload bytes, one per beat, last_byte marks the final byte of a packet.
//   result : one beat per packet, sent for the beat that carries last_byte.
//   cfg_*  : write port for match_pattern (0), pattern_length (1), terminator_byte (2);
//            write only between packets, once the previous verdict has been taken.
// Throughput: one byte per cycle, sustained; a byte is accepted in every cycle in which
//   the input register is empty or moves on. Only a last byte can wait, and only while
//   the verdict register still holds an untaken beat.
// Verdict path: a last byte accepted into the input register moves on through the search
//   logic into the verdict register, from which the verdict is offered; that move waits
//   while the verdict register still holds an untaken beat.
// Reset: clears the packet state and sets the registers to pattern 0, length 1,
//   terminator CR; the input is ready for bytes as soon as reset is released.
// Stall: while result.ready is low the verdict holds; bytes of the next packet still flow
//   until its last byte reaches the input register.
module http_header_field_locator_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    hhfl_byte_if.sink                        bytes,
    hhfl_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [hhfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hhfl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [hhfl_pkg::PAT_W-1:0]   pattern_reg;
    logic [hhfl_pkg::PLEN_W-1:0]  plen_cfg_reg;
    logic [hhfl_pkg::BYTE_W-1:0]  term_reg;

    logic                         s1_valid_reg;
    logic [hhfl_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                         s1_last_reg;

    logic [hhfl_pkg::CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [hhfl_pkg::HES_W-1:0]   hes_reg,    hes_next;
    hhfl_pkg::phase_t             phase_reg,  phase_next;
    logic                         prefix_reg, prefix_next;
    logic [hhfl_pkg::CNT_W-1:0]   off_reg,    off_next;
    logic [hhfl_pkg::CNT_W-1:0]   vcnt_reg,   vcnt_next;

    logic                         out_valid_reg;
    hhfl_pkg::verdict_t           verdict_reg,  verdict_next;
    logic [hhfl_pkg::CNT_W-1:0]   out_off_reg,  out_off_next;
    logic [hhfl_pkg::CNT_W-1:0]   out_len_reg,  out_len_next;

    logic                         go;
    logic                         in_range;
    logic [hhfl_pkg::PLEN_W-1:0]  plen;
    hhfl_pkg::win_view_t          view;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            plen_cfg_reg <= hhfl_pkg::PLEN_RESET;
            term_reg     <= hhfl_pkg::TERM_RESET;
        end
        else if (cfg_we)
        begin
            case (hhfl_pkg::cfg_index_t'(cfg_index))
                hhfl_pkg::CFG_PATTERN: pattern_reg  <= cfg_data[hhfl_pkg::PAT_W-1:0];
                hhfl_pkg::CFG_LENGTH:  plen_cfg_reg <= cfg_data[hhfl_pkg::PLEN_W-1:0];
                hhfl_pkg::CFG_TERM:    term_reg     <= cfg_data[hhfl_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // hold a last byte while the verdict register is still occupied
    assign go          = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign bytes.ready = !s1_valid_reg || go;
    assign plen        = hhfl_pkg::eff_plen(plen_cfg_reg);
    assign in_range    = cnt_reg < hhfl_pkg::CNT_W'(hhfl_pkg::PKT_MAX_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            s1_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_last_reg <= bytes.last_byte;
        end
    end

    hhfl_window u_window
    (
        .clk       (clk),
        .shift     (go && in_range),
        .data_byte (s1_byte_reg),
        .plen      (plen),
        .pattern   (pattern_reg),
        .view      (view)
    );

    always_comb
    begin
        logic [hhfl_pkg::CNT_W-1:0]  n_inc;
        logic                        below_plen;
        logic [hhfl_pkg::BYTE_W-1:0] pat_n;
        logic                        odd;
        n_inc       = cnt_reg + hhfl_pkg::CNT_W'(1);
        below_plen  = cnt_reg < hhfl_pkg::CNT_W'(plen);
        pat_n       = pattern_reg[{cnt_reg[hhfl_pkg::WIN_IDX_W-1:0], 3'b000} +: hhfl_pkg::BYTE_W];
        odd         = hes_reg[0];

        prefix_next = prefix_reg;
        cnt_next    = cnt_reg;
        hes_next    = hes_reg;
        phase_next  = phase_reg;
        off_next    = off_reg;
        vcnt_next   = vcnt_reg;

        if (below_plen && hhfl_pkg::fold(s1_byte_reg) != hhfl_pkg::fold(pat_n))
        begin
            prefix_next = 1'b0;
        end

        if (in_range)
        begin
            case (phase_reg)
                hhfl_pkg::PH_SEARCH:
                begin
                    if (n_inc >= hhfl_pkg::CNT_W'(plen))
                    begin
                        if (view.start_byte == hhfl_pkg::CH_CR)
                        begin
                            hes_next = odd ? '0 : hes_reg + hhfl_pkg::HES_W'(1);
                        end
                        else if (view.start_byte == hhfl_pkg::CH_LF)
                        begin
                            hes_next = odd ? hes_reg + hhfl_pkg::HES_W'(1) : '0;
                        end
                        else
                        begin
                            hes_next = '0;
                        end
                        if (hes_next >= hhfl_pkg::HES_END)
                        begin
                            phase_next = hhfl_pkg::PH_STOP;
                        end
                        else if (view.hit)
                        begin
                            off_next   = n_inc;
                            vcnt_next  = '0;
                            phase_next = hhfl_pkg::PH_VALUE;
                        end
                    end
                end
                hhfl_pkg::PH_VALUE:
                begin
                    if (s1_byte_reg == term_reg)
                    begin
                        phase_next = hhfl_pkg::PH_DONE;
                    end
                    else
                    begin
                        vcnt_next = vcnt_reg + hhfl_pkg::CNT_W'(1);
                    end
                end
                default: ;
            endcase
            cnt_next = n_inc;
        end

        verdict_next = hhfl_pkg::VERDICT_NONE;
        out_off_next = '0;
        out_len_next = '0;
        if (below_plen)
        begin
            verdict_next = prefix_next ? hhfl_pkg::VERDICT_PARTIAL : hhfl_pkg::VERDICT_NONE;
        end
        else if (phase_next == hhfl_pkg::PH_VALUE)
        begin
            verdict_next = hhfl_pkg::VERDICT_PARTIAL;
        end
        else if (phase_next == hhfl_pkg::PH_DONE)
        begin
            verdict_next = hhfl_pkg::VERDICT_MATCH;
            out_off_next = off_next;
            out_len_next = vcnt_next;
        end
    end

    // advance packet state; drop it back to the start after each last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            hes_reg    <= '0;
            phase_reg  <= hhfl_pkg::PH_SEARCH;
            prefix_reg <= 1'b1;
            off_reg    <= '0;
            vcnt_reg   <= '0;
        end
        else if (go)
        begin
            if (s1_last_reg)
            begin
                cnt_reg    <= '0;
                hes_reg    <= '0;
                phase_reg  <= hhfl_pkg::PH_SEARCH;
                prefix_reg <= 1'b1;
                off_reg    <= '0;
                vcnt_reg   <= '0;
            end
            else
            begin
                cnt_reg    <= cnt_next;
                hes_reg    <= hes_next;
                phase_reg  <= phase_next;
                prefix_reg <= prefix_next;
                off_reg    <= off_next;
                vcnt_reg   <= vcnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_last_reg)
        begin
            verdict_reg <= verdict_next;
            out_off_reg <= out_off_next;
            out_len_reg <= out_len_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.verdict      = verdict_reg;
    assign result.value_offset = out_off_reg;
    assign result.value_length = out_len_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hhfl_pkg::CNT_W'(hhfl_pkg::PKT_MAX_BYTES))
        else $error("byte count beyond packet limit");

    a_search_hes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hhfl_pkg::PH_SEARCH |-> hes_reg < hhfl_pkg::HES_END)
        else $error("header end complete while still searching");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg != hhfl_pkg::VERDICT_MATCH
        |-> out_off_reg == '0 && out_len_reg == '0)
        else $error("offset or length set without a match");

    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !go |=> s1_valid_reg && s1_last_reg && $stable(s1_byte_reg))
        else $error("held last byte lost from input register");
`endif

endmodule

// ----- sim/http_header_field_locator_unit_test.sv -----
// Self-checking bench for http_header_field_locator_unit: a directed table, an overlong packet,
// then random header-like packets under changing settings and random idling on both channels.
// Depends on hhfl_pkg, hhfl_byte_if, hhfl_result_if and the block itself.
module http_header_field_locator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        hhfl_pkg::verdict_t         verdict;
        logic [hhfl_pkg::CNT_W-1:0] offset;
        logic [hhfl_pkg::CNT_W-1:0] length;
    } verdict_rec_t;

    typedef struct {
        bit                   is_cfg;
        hhfl_pkg::cfg_index_t idx;
        logic [63:0]          value;
        logic [7:0]           data;
        logic                 is_last;
        bit                   typed;
        verdict_rec_t         want;
    } dir_row_t;

    typedef enum logic [3:0] {
        SCAN       = 4'b0001,
        IN_VALUE   = 4'b0010,
        TERMINATED = 4'b0100,
        HDR_END    = 4'b1000
    } scan_phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [hhfl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hhfl_pkg::CFG_DATA_W-1:0] cfg_data;

    hhfl_byte_if   bytes_ch();
    hhfl_result_if result_ch();

    http_header_field_locator_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (bytes_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Locator state and settings as the block should hold them
    logic [63:0] m_pat;
    logic [3:0]  m_plen;
    logic [7:0]  m_term;
    logic [7:0]  win [0:7];
    int unsigned cnt;
    int unsigned hes;
    scan_phase_t sph;
    bit          pref_ok;
    int unsigned fnd_off;
    int unsigned val_cnt;

    verdict_rec_t pending_verdicts[$];
    dir_row_t     dir_rows[$];
    logic [7:0]   pkt[$];
    verdict_rec_t no_rec;

    bit src_calm;
    bit sink_calm;
    int n_errors;
    int n_packets;
    int n_bytes;
    int n_settings;
    int n_match;
    int n_partial;
    int n_none;

    function automatic int unsigned used_len();
        if (m_plen == 4'd0)
        begin
            return 1;
        end
        if (m_plen > 4'(hhfl_pkg::PAT_MAX_BYTES))
        begin
            return hhfl_pkg::PAT_MAX_BYTES;
        end
        return m_plen;
    endfunction

    function automatic logic [7:0] lower_case(logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pat_at(int unsigned i);
        return m_pat[i*8 +: 8];
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return hhfl_pkg::CH_CR;
            2: return hhfl_pkg::CH_LF;
            3: return 8'h3A;
            4: return 8'h20;
            5, 6: return 8'($urandom_range(8'h61, 8'h7A));
            default: return 8'($urandom_range(8'h41, 8'h5A));
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return pick_char();
    endfunction

    function automatic dir_row_t row_cfg(hhfl_pkg::cfg_index_t idx, logic [63:0] v);
        dir_row_t r;
        r.is_cfg  = 1'b1;
        r.idx     = idx;
        r.value   = v;
        r.data    = '0;
        r.is_last = 1'b0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic dir_row_t row_byte(logic [7:0] d, logic l);
        dir_row_t r;
        r         = row_cfg(hhfl_pkg::CFG_PATTERN, '0);
        r.is_cfg  = 1'b0;
        r.data    = d;
        r.is_last = l;
        return r;
    endfunction

    function automatic dir_row_t row_check(logic [7:0] d, hhfl_pkg::verdict_t v,
                                           int off, int len);
        dir_row_t r;
        r              = row_byte(d, 1'b1);
        r.typed        = 1'b1;
        r.want.verdict = v;
        r.want.offset  = hhfl_pkg::CNT_W'(off);
        r.want.length  = hhfl_pkg::CNT_W'(len);
        return r;
    endfunction

    task automatic clear_packet();
        for (int k = 0; k < 8; k++)
        begin
            win[k] = '0;
        end
        cnt     = 0;
        hes     = 0;
        sph     = SCAN;
        pref_ok = 1'b1;
        fnd_off = 0;
        val_cnt = 0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic is_last, output bit emit,
                             output verdict_rec_t rec);
        int unsigned plen;
        int unsigned n;
        logic [7:0]  s;
        bit          odd;
        bit          eq;
        plen = used_len();
        n    = cnt;
        emit = 1'b0;
        rec  = '0;
        if (n < plen && lower_case(b) != lower_case(pat_at(n)))
        begin
            pref_ok = 1'b0;
        end
        if (n < hhfl_pkg::PKT_MAX_BYTES)
        begin
            for (int k = 7; k > 0; k--)
            begin
                win[k] = win[k-1];
            end
            win[0] = b;
            if (sph == SCAN)
            begin
                if (n + 1 >= plen)
                begin
                    s   = win[plen-1];
                    odd = hes[0];
                    if (s == hhfl_pkg::CH_CR)
                    begin
                        hes = odd ? 0 : hes + 1;
                    end
                    else if (s == hhfl_pkg::CH_LF)
                    begin
                        hes = odd ? hes + 1 : 0;
                    end
                    else
                    begin
                        hes = 0;
                    end
                    if (hes >= 4)
                    begin
                        sph = HDR_END;
                    end
                    else
                    begin
                        eq = 1'b1;
                        for (int unsigned k = 0; k < plen; k++)
                        begin
                            if (win[plen-1-k] != pat_at(k))
                            begin
                                eq = 1'b0;
                            end
                        end
                        if (eq)
                        begin
                            fnd_off = n + 1;
                            val_cnt = 0;
                            sph     = IN_VALUE;
                        end
                    end
                end
            end
            else if (sph == IN_VALUE)
            begin
                if (b == m_term)
                begin
                    sph = TERMINATED;
                end
                else
                begin
                    val_cnt++;
                end
            end
            cnt = n + 1;
        end
        if (is_last)
        begin
            emit = 1'b1;
            rec.verdict = hhfl_pkg::VERDICT_NONE;
            if (n + 1 <= plen)
            begin
                rec.verdict = pref_ok ? hhfl_pkg::VERDICT_PARTIAL : hhfl_pkg::VERDICT_NONE;
            end
            else if (sph == IN_VALUE)
            begin
                rec.verdict = hhfl_pkg::VERDICT_PARTIAL;
            end
            else if (sph == TERMINATED)
            begin
                rec.verdict = hhfl_pkg::VERDICT_MATCH;
                rec.offset  = hhfl_pkg::CNT_W'(fnd_off);
                rec.length  = hhfl_pkg::CNT_W'(val_cnt);
            end
            clear_packet();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last, input bit typed,
                             input verdict_rec_t typed_rec);
        int           gap;
        bit           emit;
        verdict_rec_t rec;
        gap = src_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.last_byte <= is_last;
        @(posedge clk);
        while (!bytes_ch.ready) @(posedge clk);
        scan_byte(b, is_last, emit, rec);
        n_bytes++;
        if (emit)
        begin
            n_packets++;
            pending_verdicts.push_back(typed ? typed_rec : rec);
        end
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
        begin
            send_byte(pkt[i], i == pkt.size() - 1, 1'b0, no_rec);
        end
    endtask

    task automatic wait_idle();
        bytes_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input hhfl_pkg::cfg_index_t idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            hhfl_pkg::CFG_PATTERN: m_pat  = v;
            hhfl_pkg::CFG_LENGTH:  m_plen = v[3:0];
            hhfl_pkg::CFG_TERM:    m_term = v[7:0];
            default: ;
        endcase
    endtask

    task automatic new_setting(input int plen_val);
        logic [63:0] pat;
        logic [63:0] junk;
        logic [7:0]  term;
        for (int i = 0; i < 8; i++)
        begin
            pat[i*8 +: 8] = pick_char();
        end
        case ($urandom_range(0, 5))
            0: term = hhfl_pkg::CH_CR;
            1: term = 8'h00;
            2: term = 8'hFF;
            3: term = 8'h3B;
            default: term = pick_char();
        endcase
        junk = {$urandom, $urandom};
        wait_idle();
        write_reg(hhfl_pkg::CFG_PATTERN, pat);
        write_reg(hhfl_pkg::CFG_LENGTH, {junk[63:4], 4'(plen_val)});
        write_reg(hhfl_pkg::CFG_TERM, {junk[63:8], term});
        cfg_we <= 1'b0;
        n_settings++;
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic build_packet();
        int unsigned plen;
        int          style;
        int          r;
        logic [7:0]  c;
        plen = used_len();
        pkt.delete();
        style = $urandom_range(0, 9);
        if (style < 6)
        begin
            repeat ($urandom_range(0, 6)) pkt.push_back(noise_byte());
            if ($urandom_range(0, 3) == 0)
            begin
                pkt.push_back(hhfl_pkg::CH_CR);
                pkt.push_back(hhfl_pkg::CH_LF);
                if ($urandom_range(0, 2) == 0)
                begin
                    pkt.push_back(hhfl_pkg::CH_CR);
                    pkt.push_back(hhfl_pkg::CH_LF);
                end
            end
            for (int unsigned i = 0; i < plen; i++)
            begin
                c = pat_at(i);
                r = $urandom_range(0, 11);
                if (r == 0)
                begin
                    c = flip_case(c);
                end
                else if (r == 1)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                pkt.push_back(c);
            end
            repeat ($urandom_range(0, 12))
            begin
                c = noise_byte();
                if (c == m_term)
                begin
                    c = c ^ 8'h01;
                end
                pkt.push_back(c);
            end
            if ($urandom_range(0, 5) != 0)
            begin
                pkt.push_back(m_term);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                pkt.push_back(hhfl_pkg::CH_CR);
                pkt.push_back(hhfl_pkg::CH_LF);
                if ($urandom_range(0, 2) == 0)
                begin
                    pkt.push_back(hhfl_pkg::CH_CR);
                    pkt.push_back(hhfl_pkg::CH_LF);
                end
            end
            repeat ($urandom_range(0, 4)) pkt.push_back(noise_byte());
        end
        else if (style < 8)
        begin
            repeat ($urandom_range(1, plen))
            begin
                c = pat_at(pkt.size());
                r = $urandom_range(0, 5);
                if (r < 2)
                begin
                    c = flip_case(c);
                end
                else if (r == 2)
                begin
                    c = 8'($urandom_range(0, 255));
                end
                pkt.push_back(c);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 30)) pkt.push_back(noise_byte());
        end
    endtask

    task automatic build_overlong();
        int unsigned plen;
        int          len;
        int          place;
        int          term_at;
        logic [7:0]  c;
        plen = used_len();
        len  = 2044 + $urandom_range(0, 12);
        pkt.delete();
        repeat (len)
        begin
            c = 8'($urandom_range(0, 255));
            pkt.push_back(c == hhfl_pkg::CH_CR ? 8'h20 : c);
        end
        place = $urandom_range(1990, 2046);
        for (int unsigned i = 0; i < plen; i++)
        begin
            if (place + i < len)
            begin
                pkt[place + i] = pat_at(i);
            end
        end
        term_at = place + plen + $urandom_range(0, 12);
        if (term_at < len)
        begin
            pkt[term_at] = m_term;
        end
    endtask

    initial
    begin
        no_rec = '0;
        m_pat  = '0;
        m_plen = hhfl_pkg::PLEN_RESET;
        m_term = hhfl_pkg::TERM_RESET;
        clear_packet();
    end

    initial
    begin
        int  stall;
        verdict_rec_t want;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
            case (result_ch.verdict)
                hhfl_pkg::VERDICT_MATCH:   n_match++;
                hhfl_pkg::VERDICT_PARTIAL: n_partial++;
                default:                   n_none++;
            endcase
            if (pending_verdicts.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                begin
                    $display("unexpected verdict beat: verdict %0d offset %0d length %0d",
                             result_ch.verdict, result_ch.value_offset,
                             result_ch.value_length);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (result_ch.verdict !== want.verdict || result_ch.value_offset !== want.offset
                    || result_ch.value_length !== want.length)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 want.verdict, want.offset, want.length, result_ch.verdict,
                                 result_ch.value_offset, result_ch.value_length);
                    end
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        bit cfg_open;
        int random_bytes;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= hhfl_pkg::CFG_PATTERN;
        cfg_data           <= '0;
        bytes_ch.valid     <= 1'b0;
        bytes_ch.data_byte <= '0;
        bytes_ch.last_byte <= 1'b0;
        src_calm  = 1'b0;
        sink_calm = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        dir_rows.push_back(row_check(8'h00, hhfl_pkg::VERDICT_PARTIAL, 0, 0));
        dir_rows.push_back(row_check(8'hFF, hhfl_pkg::VERDICT_NONE, 0, 0));
        dir_rows.push_back(row_byte(8'h00, 1'b0));
        dir_rows.push_back(row_byte(8'h05, 1'b0));
        dir_rows.push_back(row_check(hhfl_pkg::CH_CR, hhfl_pkg::VERDICT_MATCH, 1, 1));
        dir_rows.push_back(row_byte(8'h00, 1'b0));
        dir_rows.push_back(row_check(8'h41, hhfl_pkg::VERDICT_PARTIAL, 0, 0));
        dir_rows.push_back(row_byte(8'h07, 1'b0));
        dir_rows.push_back(row_check(8'h00, hhfl_pkg::VERDICT_PARTIAL, 0, 0));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_PATTERN, 64'h6241));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_LENGTH, 64'd2));
        dir_rows.push_back(row_byte(hhfl_pkg::CH_CR, 1'b0));
        dir_rows.push_back(row_byte(hhfl_pkg::CH_LF, 1'b0));
        dir_rows.push_back(row_byte(hhfl_pkg::CH_CR, 1'b0));
        dir_rows.push_back(row_byte(hhfl_pkg::CH_LF, 1'b0));
        dir_rows.push_back(row_byte(8'h41, 1'b1));
        dir_rows.push_back(row_byte(8'h61, 1'b0));
        dir_rows.push_back(row_check(8'h42, hhfl_pkg::VERDICT_PARTIAL, 0, 0));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_LENGTH, 64'd0));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_TERM, 64'h00));
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_check(8'h00, hhfl_pkg::VERDICT_MATCH, 1, 0));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_LENGTH, 64'd15));
        dir_rows.push_back(row_cfg(hhfl_pkg::CFG_TERM, 64'hFF));
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_byte(8'hFF, 1'b0));
        dir_rows.push_back(row_check(8'hFE, hhfl_pkg::VERDICT_NONE, 0, 0));

        cfg_open = 1'b0;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                if (!cfg_open)
                begin
                    wait_idle();
                    n_settings++;
                end
                write_reg(dir_rows[i].idx, dir_rows[i].value);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_byte(dir_rows[i].data, dir_rows[i].is_last, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end

        // Overlong packet: searching and counting stop at the size limit
        new_setting($urandom_range(1, 8));
        src_calm = 1'b1;
        build_overlong();
        send_packet();

        random_bytes = 0;
        while (random_bytes < 600)
        begin
            case ($urandom_range(0, 9))
                0: new_setting(0);
                1: new_setting($urandom_range(9, 15));
                2: new_setting(8);
                3: new_setting(1);
                default: new_setting($urandom_range(1, 8));
            endcase
            repeat ($urandom_range(3, 10))
            begin
                build_packet();
                send_packet();
                random_bytes += pkt.size();
                if ($urandom_range(0, 7) == 0)
                begin
                    wait_idle();
                end
            end
        end

        bytes_ch.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d packets, %0d bytes, %0d register settings.",
                 n_packets, n_bytes, n_settings);
        $display("Verdicts seen: %0d match, %0d partial, %0d no match; %0d mismatches.",
                 n_match, n_partial, n_none, n_errors);
        if (n_errors == 0 && pending_verdicts.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hhfl_pkg.sv
hdl/hhfl_byte_if.sv
hdl/hhfl_result_if.sv
hdl/hhfl_window.sv
hdl/http_header_field_locator_unit.sv
sim/http_header_field_locator_unit_test.sv
